[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the dual LED blink controller.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted (active low).
`define DLBC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked property that also holds during reset.
`define DLBC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define DLBC_ASSERT(label, clk, rst_n, prop)
`define DLBC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/dlbc_pkg.sv]
// Package for the dual LED blink controller: pattern codes, register
// field codes and the pattern-apply function. No dependencies.
`default_nettype none

package dlbc_pkg;

  // Pattern codes; anything else leaves the LED levels unchanged.
  typedef enum logic [3:0] {
    PAT_NONE      = 4'd0,
    PAT_NET_OFF   = 4'd1,
    PAT_COM_OFF   = 4'd2,
    PAT_NET_ON    = 4'd3,
    PAT_COM_ON    = 4'd4,
    PAT_NET_GREEN = 4'd5,
    PAT_NET_RED   = 4'd6,
    PAT_COM_GREEN = 4'd7,
    PAT_COM_RED   = 4'd8
  } pattern_e;

  // Register slot within one channel's group of four.
  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_COUNT    = 2'd1,
    REG_PATTERN  = 2'd2,
    REG_ALT      = 2'd3
  } reg_field_e;

  localparam int unsigned NUM_CH         = 2;
  localparam int unsigned CH_NET         = 0;
  localparam int unsigned CH_COM         = 1;
  localparam int unsigned INTERVAL_W     = 32;
  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned PATTERN_W      = 4;
  localparam int unsigned APB_ADDR_W     = 5;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned MAX_TICK_BITS  = 64;
  localparam int unsigned MAX_COUNT_BITS = 32;

  // LED level bits: 0 net green, 1 net red, 2 com green, 3 com red.
  localparam logic [3:0] LED_RESET = 4'b1010;

  typedef logic [3:0] led_t;

  function automatic led_t apply_pattern(led_t lv, logic [PATTERN_W-1:0] p);
    led_t r;
    r = lv;
    case (p)
      PAT_NET_OFF:   r = lv & 4'b1100;
      PAT_COM_OFF:   r = lv & 4'b0011;
      PAT_NET_ON:    r = lv | 4'b0011;
      PAT_COM_ON:    r = lv | 4'b1100;
      PAT_NET_GREEN: r = {lv[3:2], 2'b01};
      PAT_NET_RED:   r = {lv[3:2], 2'b10};
      PAT_COM_GREEN: r = {2'b01, lv[1:0]};
      PAT_COM_RED:   r = {2'b10, lv[1:0]};
      default:       r = lv;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/dual_led_blink_controller.sv]
// Dual LED blink controller top level: APB register file, per-channel
// blink state and a two-deep result buffer. Uses dlbc_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Two blink channels (network, communication) drive four LED levels. Each
// tick transfer on the input channel is one call of the periodic handler and
// carries the current time stamp; it yields exactly one transfer of the four
// LED levels on the output channel. A channel with interval 0 keeps showing
// its main pattern; otherwise it alternates between main and alternate
// pattern every time the ticks elapsed since its last toggle reach the
// interval, counting down a nonzero blink count and freezing once it runs
// out. The network channel is evaluated before the communication channel, so
// the communication channel wins on a shared LED. Writing any register of a
// channel rearms it at the next tick transfer (main pattern shown again).
// Registers sit at byte address 4*i: 0 net_interval, 1 net_blink_count,
// 2 net_pattern, 3 net_alt_pattern, 4..7 the same for the communication
// channel. Write registers only while no tick transfer is in flight.
// Rate: one tick transfer per cycle while fewer than two results are held;
// the result is registered into the result buffer. The whole update is a
// subtract and a compare per channel and a four-step pattern decode between
// the state registers. A two-entry result buffer keeps in_ready_o high while
// one result waits; it drops only when two results are held.
module dual_led_blink_controller #(
  parameter int unsigned TICK_BITS  = 32,  // 8..64
  parameter int unsigned COUNT_BITS = 16   // 1..32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // tick input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] now_tick_i,
  // LED level output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             net_green_led_o,
  output logic             net_red_led_o,
  output logic             com_green_led_o,
  output logic             com_red_led_o
);

  localparam int unsigned NCH = dlbc_pkg::NUM_CH;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [dlbc_pkg::INTERVAL_W-1:0] interval_q [NCH];
  logic [dlbc_pkg::COUNT_W-1:0]    count_q    [NCH];
  logic [dlbc_pkg::PATTERN_W-1:0]  pat_q      [NCH];
  logic [dlbc_pkg::PATTERN_W-1:0]  alt_q      [NCH];

  logic       cfg_wr;
  logic       cfg_ch;     // 0 network, 1 communication
  logic [1:0] cfg_field;
  logic [NCH-1:0] rearm_set;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign cfg_ch    = paddr[4];
  assign cfg_field = paddr[3:2];

  always_comb begin
    rearm_set = '0;
    if (cfg_wr) begin
      rearm_set[cfg_ch] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        interval_q[c] <= '0;
        count_q[c]    <= '0;
        pat_q[c]      <= '0;
        alt_q[c]      <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_field)
        dlbc_pkg::REG_INTERVAL: interval_q[cfg_ch] <= pwdata;
        dlbc_pkg::REG_COUNT:    count_q[cfg_ch]    <= pwdata[dlbc_pkg::COUNT_W-1:0];
        dlbc_pkg::REG_PATTERN:  pat_q[cfg_ch]      <= pwdata[dlbc_pkg::PATTERN_W-1:0];
        dlbc_pkg::REG_ALT:      alt_q[cfg_ch]      <= pwdata[dlbc_pkg::PATTERN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back, zero extended
  always_comb begin
    prdata = '0;
    unique case (cfg_field)
      dlbc_pkg::REG_INTERVAL: prdata = interval_q[cfg_ch];
      dlbc_pkg::REG_COUNT:    prdata = {16'd0, count_q[cfg_ch]};
      dlbc_pkg::REG_PATTERN:  prdata = {28'd0, pat_q[cfg_ch]};
      dlbc_pkg::REG_ALT:      prdata = {28'd0, alt_q[cfg_ch]};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Blink state
  // ---------------------------------------------------------------------
  logic [NCH-1:0]        rearm_q, rearm_d;
  logic                  phase_q   [NCH];
  logic                  phase_d   [NCH];
  logic                  shown_q   [NCH];
  logic                  shown_d   [NCH];
  logic                  startn_q  [NCH];  // start time capture pending
  logic                  startn_d  [NCH];
  logic [COUNT_BITS-1:0] toggles_q [NCH];
  logic [COUNT_BITS-1:0] toggles_d [NCH];
  logic [TICK_BITS-1:0]  start_q   [NCH];
  logic [TICK_BITS-1:0]  start_d   [NCH];
  dlbc_pkg::led_t        led_q, led_d, led_calc;

  logic                  in_xfer;
  logic [dlbc_pkg::MAX_TICK_BITS-1:0]  now_w;
  logic [TICK_BITS-1:0]                now_t;
  logic [dlbc_pkg::MAX_COUNT_BITS-1:0] cnt_w    [NCH];
  logic [dlbc_pkg::MAX_TICK_BITS-1:0]  elapsed_w[NCH];
  logic [dlbc_pkg::MAX_TICK_BITS-1:0]  iv_w     [NCH];
  logic                  main_en  [NCH];  // interval 0: main pattern every tick
  logic                  show_en  [NCH];  // phase changed: show its pattern
  logic [dlbc_pkg::PATTERN_W-1:0] show_pat [NCH];

  assign in_xfer = in_valid_i & in_ready_o;

  always_comb begin
    now_w = '0;
    now_w[31:0] = now_tick_i;
    now_t = now_w[TICK_BITS-1:0];

    for (int c = 0; c < NCH; c++) begin
      toggles_d[c] = toggles_q[c];
      phase_d[c]   = phase_q[c];
      shown_d[c]   = shown_q[c];
      startn_d[c]  = startn_q[c];
      start_d[c]   = start_q[c];
      main_en[c]   = 1'b0;
      show_en[c]   = 1'b0;
      show_pat[c]  = pat_q[c];
      cnt_w[c]     = '0;
      cnt_w[c][dlbc_pkg::COUNT_W-1:0] = count_q[c];
      elapsed_w[c] = '0;
      iv_w[c]      = '0;
      iv_w[c][dlbc_pkg::INTERVAL_W-1:0] = interval_q[c];

      if (rearm_q[c]) begin
        startn_d[c]  = 1'b1;
        toggles_d[c] = cnt_w[c][COUNT_BITS-1:0];
        phase_d[c]   = 1'b0;
        shown_d[c]   = 1'b1;
      end

      // Limited count at zero: channel frozen
      if (!(toggles_d[c] == '0 && count_q[c] != '0)) begin
        if (interval_q[c] == '0) begin
          main_en[c] = 1'b1;
        end else begin
          if (startn_d[c]) begin
            startn_d[c] = 1'b0;
            start_d[c]  = now_t;
          end
          elapsed_w[c][TICK_BITS-1:0] = now_t - start_d[c];
          if (elapsed_w[c] >= iv_w[c]) begin
            startn_d[c] = 1'b1;
            phase_d[c]  = ~phase_d[c];
            if (count_q[c] != '0) begin
              toggles_d[c] = toggles_d[c] - COUNT_BITS'(1);
            end
          end
        end
        if (phase_d[c] != shown_d[c]) begin
          shown_d[c]  = phase_d[c];
          show_en[c]  = 1'b1;
          show_pat[c] = phase_d[c] ? alt_q[c] : pat_q[c];
        end
      end
    end

    // Network first, then communication; later writes win
    led_calc = led_q;
    for (int c = 0; c < NCH; c++) begin
      if (main_en[c]) begin
        led_calc = dlbc_pkg::apply_pattern(led_calc, pat_q[c]);
      end
      if (show_en[c]) begin
        led_calc = dlbc_pkg::apply_pattern(led_calc, show_pat[c]);
      end
    end

    led_d   = in_xfer ? led_calc : led_q;
    rearm_d = (in_xfer ? '0 : rearm_q) | rearm_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rearm_q <= '0;
      led_q   <= dlbc_pkg::LED_RESET;
      for (int c = 0; c < NCH; c++) begin
        phase_q[c]   <= 1'b0;
        shown_q[c]   <= 1'b1;
        startn_q[c]  <= 1'b1;
        toggles_q[c] <= '0;
        start_q[c]   <= '0;
      end
    end else begin
      rearm_q <= rearm_d;
      led_q   <= led_d;
      if (in_xfer) begin
        for (int c = 0; c < NCH; c++) begin
          phase_q[c]   <= phase_d[c];
          shown_q[c]   <= shown_d[c];
          startn_q[c]  <= startn_d[c];
          toggles_q[c] <= toggles_d[c];
          start_q[c]   <= start_d[c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Two-entry result buffer; head entry drives the outputs
  // ---------------------------------------------------------------------
  logic [1:0]     fill_q, fill_d;
  dlbc_pkg::led_t buf0_q, buf0_d, buf1_q, buf1_d;
  logic           out_xfer;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_xfer    = out_valid_o & out_ready_i;

  always_comb begin
    fill_d = fill_q;
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    case ({in_xfer, out_xfer})
      2'b11: begin
        if (fill_q == 2'd1) begin
          buf0_d = led_calc;
        end else begin
          buf0_d = buf1_q;
          buf1_d = led_calc;
        end
      end
      2'b10: begin
        fill_d = fill_q + 2'd1;
        if (fill_q == 2'd0) begin
          buf0_d = led_calc;
        end else begin
          buf1_d = led_calc;
        end
      end
      2'b01: begin
        fill_d = fill_q - 2'd1;
        buf0_d = buf1_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  assign net_green_led_o = buf0_q[0];
  assign net_red_led_o   = buf0_q[1];
  assign com_green_led_o = buf0_q[2];
  assign com_red_led_o   = buf0_q[3];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // buffer never holds more than two results
  `DLBC_ASSERT_ALWAYS(a_fill_range, clk_i, (!rst_ni) || (fill_q != 2'd3))
  // a result pushed without a pop is visible next cycle
  `DLBC_ASSERT(a_push_visible, clk_i, rst_ni, (in_xfer && !out_xfer) |=> out_valid_o)
  // a tick transfer consumes every pending rearm not renewed in that cycle
  `DLBC_ASSERT(a_rearm_consumed, clk_i, rst_ni, (in_xfer && !cfg_wr) |=> (rearm_q == '0))
  // a frozen network channel keeps its phase
  `DLBC_ASSERT(a_net_frozen, clk_i, rst_ni,
    (in_xfer && !rearm_q[0] && toggles_q[0] == '0 && count_q[0] != '0) |=>
    (phase_q[0] == $past(phase_q[0])))

endmodule

`default_nettype wire
